### hdl/cdwc_pkg.sv
// Shared types, codes and helpers for the command driven wall clock.
// Depends on nothing; imported by hdl/command_driven_wall_clock.sv.
package cdwc_pkg;

  localparam int unsigned MSG_DEPTH = 12;
  localparam logic [3:0]  LEN_MAX   = 4'd15;

  // item codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_CHAR = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_SHOW  = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [3:0] ERR_R_LEN   = 4'd0;
  localparam logic [3:0] ERR_S_LEN   = 4'd1;
  localparam logic [3:0] ERR_SPACE   = 4'd2;
  localparam logic [3:0] ERR_COLON   = 4'd3;
  localparam logic [3:0] ERR_HOUR    = 4'd4;
  localparam logic [3:0] ERR_MINUTE  = 4'd5;
  localparam logic [3:0] ERR_SECOND  = 4'd6;
  localparam logic [3:0] ERR_T_LEN   = 4'd7;
  localparam logic [3:0] ERR_UNKNOWN = 4'd8;

  // message lengths that the commands require
  localparam logic [3:0] LEN_SHORT_CMD = 4'd5;
  localparam logic [3:0] LEN_SET_CMD   = 4'd14;

  // characters
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_W       = 8'h57;
  localparam logic [7:0] CH_R       = 8'h52;
  localparam logic [7:0] CH_S       = 8'h53;
  localparam logic [7:0] CH_T       = 8'h54;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_NUL     = 8'h00;

  typedef logic [7:0] char_t;
  typedef char_t [MSG_DEPTH-1:0] msg_t;

  // time of day kept in mixed radix, always normalized to one day
  typedef struct packed {
    logic [4:0] h;
    logic [5:0] m;
    logic [5:0] s;
  } hms_t;

  function automatic logic is_digit(input char_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // two decimal digits to a value of at most 99
  function automatic logic [6:0] pair_value(input char_t tens, input char_t ones);
    logic [6:0] t;
    logic [6:0] o;
    t = {3'd0, tens[3:0]};
    o = {3'd0, ones[3:0]};
    return 7'((t << 3) + (t << 1) + o);
  endfunction

  // reduce a value of at most 127 modulo 24: parallel compares, one subtract
  function automatic logic [4:0] mod24(input logic [6:0] v);
    logic [6:0] r;
    priority if (v >= 7'd120) begin
      r = 7'(v - 7'd120);
    end else if (v >= 7'd96) begin
      r = 7'(v - 7'd96);
    end else if (v >= 7'd72) begin
      r = 7'(v - 7'd72);
    end else if (v >= 7'd48) begin
      r = 7'(v - 7'd48);
    end else if (v >= 7'd24) begin
      r = 7'(v - 7'd24);
    end else begin
      r = v;
    end
    return r[4:0];
  endfunction

  // advance by one second, wrap at midnight
  function automatic hms_t hms_inc(input hms_t t);
    hms_t r;
    r = t;
    if (t.s == 6'd59) begin
      r.s = 6'd0;
      if (t.m == 6'd59) begin
        r.m = 6'd0;
        r.h = (t.h == 5'd23) ? 5'd0 : 5'(t.h + 5'd1);
      end else begin
        r.m = 6'(t.m + 6'd1);
      end
    end else begin
      r.s = 6'(t.s + 6'd1);
    end
    return r;
  endfunction

endpackage

### hdl/command_driven_wall_clock.sv
// Command driven wall clock: message assembly, command decode and time keeping.
// Depends on cdwc_pkg (hdl/cdwc_pkg.sv).
//
// Path: an accepted beat is held in the input register, then decoded and its
//   result (if any) written to the result register, which drives out_*.
// Throughput: one beat per cycle unless a stalled result holds it, limited by
//   the single decode stage that reads and updates the message and time
//   registers in the same cycle.
// Reset: synchronous active-low rst_n clears both stages, the message buffer,
//   the time (00:00:00) and leaves the clock stopped.
module command_driven_wall_clock (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_command,
  input  logic [7:0] in_char_code,
  input  logic       in_end_of_message,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_result_kind,
  output logic [4:0] out_hours,
  output logic [5:0] out_minutes,
  output logic [5:0] out_secs,
  output logic [3:0] out_error_code,
  output logic [3:0] out_message_length
);
  import cdwc_pkg::*;

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_cmd_r;
  char_t      s1_ch_r;
  logic       s1_eom_r;

  // block state
  msg_t       msg_r, msg_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       zs_r, zs_nxt;
  hms_t       time_r, time_nxt;
  logic       run_r, run_nxt;

  // result register
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] kind_r, kind_nxt;
  hms_t       show_r, show_nxt;
  logic [3:0] code_r, code_nxt;
  logic [3:0] len_r, len_nxt;

  logic       adv;
  logic       take;
  logic       fire;
  logic       has_res;

  // Decode advances whenever the result register is free or being drained.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign take     = in_valid && !in_stall;
  assign fire     = s1_valid_r && adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Decode: fold the character into the message, evaluate on the last one.
  always_comb begin
    msg_t       m;
    logic [3:0] len;
    hms_t       load;
    logic       do_start;
    logic [6:0] ss;
    logic [6:0] mm;
    logic [6:0] hh;

    m        = msg_r;
    len      = cnt_r;
    load     = time_r;
    do_start = 1'b0;
    ss       = 7'd0;
    mm       = 7'd0;
    hh       = 7'd0;

    msg_nxt  = msg_r;
    cnt_nxt  = cnt_r;
    zs_nxt   = zs_r;
    time_nxt = time_r;
    run_nxt  = run_r;

    has_res  = 1'b0;
    kind_nxt = KIND_SHOW;
    show_nxt = '0;
    code_nxt = 4'd0;
    len_nxt  = 4'd0;

    if (s1_cmd_r == CMD_TICK) begin
      // show, then advance, only while running
      if (run_r) begin
        has_res  = 1'b1;
        show_nxt = time_r;
        time_nxt = hms_inc(time_r);
      end
    end else begin
      zs_nxt = zs_r;
      if (!zs_r) begin
        if (s1_ch_r == CH_NUL) begin
          zs_nxt = 1'b1;
        end else begin
          for (int i = 0; i < MSG_DEPTH; i++) begin
            if (cnt_r == 4'(i)) m[i] = s1_ch_r;
          end
          if (cnt_r != LEN_MAX) len = 4'(cnt_r + 4'd1);
        end
      end
      msg_nxt = m;
      cnt_nxt = len;

      if (s1_eom_r) begin
        // drop the message whatever it held
        msg_nxt = '0;
        cnt_nxt = 4'd0;
        zs_nxt  = 1'b0;

        if (len >= 4'd2 && m[0] == CH_PERCENT && m[1] == CH_W) begin
          priority if (m[2] == CH_R) begin
            if (len != LEN_SHORT_CMD) begin
              has_res  = 1'b1;
              kind_nxt = KIND_ERROR;
              code_nxt = ERR_R_LEN;
              len_nxt  = len;
            end else begin
              load     = '0;
              do_start = 1'b1;
            end
          end else if (m[2] == CH_S) begin
            has_res  = 1'b1;
            kind_nxt = KIND_ERROR;
            len_nxt  = len;
            priority if (len != LEN_SET_CMD) begin
              code_nxt = ERR_S_LEN;
            end else if (m[3] != CH_SPACE) begin
              code_nxt = ERR_SPACE;
            end else if (m[6] != CH_COLON || m[9] != CH_COLON) begin
              code_nxt = ERR_COLON;
            end else if (!is_digit(m[4]) || !is_digit(m[5])) begin
              code_nxt = ERR_HOUR;
            end else if (!is_digit(m[7]) || !is_digit(m[8])) begin
              code_nxt = ERR_MINUTE;
            end else if (!is_digit(m[10]) || !is_digit(m[11])) begin
              code_nxt = ERR_SECOND;
            end else begin
              // well formed: normalize HH:MM:SS (each up to 99) into one day
              has_res  = 1'b0;
              kind_nxt = KIND_SHOW;
              len_nxt  = 4'd0;
              ss = pair_value(m[10], m[11]);
              mm = pair_value(m[7], m[8]);
              hh = pair_value(m[4], m[5]);
              if (ss >= 7'd60) begin
                ss = 7'(ss - 7'd60);
                mm = 7'(mm + 7'd1);
              end
              if (mm >= 7'd60) begin
                mm = 7'(mm - 7'd60);
                hh = 7'(hh + 7'd1);
              end
              load.s   = ss[5:0];
              load.m   = mm[5:0];
              load.h   = mod24(hh);
              do_start = 1'b1;
            end
          end else if (m[2] == CH_T) begin
            has_res = 1'b1;
            if (len != LEN_SHORT_CMD) begin
              kind_nxt = KIND_ERROR;
              code_nxt = ERR_T_LEN;
              len_nxt  = len;
            end else begin
              kind_nxt = KIND_CLEAR;
              run_nxt  = 1'b0;
            end
          end else begin
            has_res  = 1'b1;
            kind_nxt = KIND_ERROR;
            code_nxt = ERR_UNKNOWN;
            len_nxt  = len;
          end

          // reset and set load the time; a start from stopped shows and advances it
          if (do_start) begin
            time_nxt = load;
            run_nxt  = 1'b1;
            if (!run_r) begin
              has_res  = 1'b1;
              kind_nxt = KIND_SHOW;
              show_nxt = load;
              time_nxt = hms_inc(load);
            end
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) out_valid_nxt = fire && has_res;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      msg_r       <= '0;
      cnt_r       <= 4'd0;
      zs_r        <= 1'b0;
      time_r      <= '0;
      run_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        msg_r  <= msg_nxt;
        cnt_r  <= cnt_nxt;
        zs_r   <= zs_nxt;
        time_r <= time_nxt;
        run_r  <= run_nxt;
      end
    end
  end

  // payload registers: load on accept / on decode, hold otherwise
  always_ff @(posedge clk) begin
    if (take) begin
      s1_cmd_r <= in_command;
      s1_ch_r  <= in_char_code;
      s1_eom_r <= in_end_of_message;
    end
    if (fire) begin
      kind_r <= kind_nxt;
      show_r <= show_nxt;
      code_r <= code_nxt;
      len_r  <= len_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = kind_r;
  assign out_hours          = show_r.h;
  assign out_minutes        = show_r.m;
  assign out_secs           = show_r.s;
  assign out_error_code     = code_r;
  assign out_message_length = len_r;

  // the kept time never leaves one day
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    time_r.s < 6'd60 && time_r.m < 6'd60 && time_r.h < 5'd24)
    else $error("time register out of range");

  // only show results carry a time
  a_show_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r != KIND_SHOW |-> show_r == '0)
    else $error("time fields set on a non-show result");

  // a tick on a stopped clock yields nothing
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_cmd_r == CMD_TICK && !run_r |=> !out_valid_r)
    else $error("result from a tick while stopped");

  // back pressure only while an item waits in the input register
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a waiting item");

endmodule

### tb/wall_clock_board_pkg.sv
// Scoreboard for the command driven wall clock: predicts results and checks them.
// Depends on cdwc_pkg (hdl/cdwc_pkg.sv) for characters, kinds and error codes.
package wall_clock_board_pkg;
  import cdwc_pkg::*;

  localparam int unsigned DAY_SECS  = 60 * 60 * 24;
  localparam int unsigned HOUR_SECS = 3600;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] secs;
    logic [3:0] code;
    logic [3:0] msg_length;
  } clock_result_t;

  class wall_clock_board;
    char_t         msg_buf[MSG_DEPTH];
    logic [3:0]    msg_len;
    bit            nul_seen;
    int unsigned   day_secs;
    bit            running;
    clock_result_t due[$];
    int            mismatches;
    int            shows;
    int            clears;
    int            errors;
    logic [8:0]    codes_seen;

    function new();
      clear_msg();
      day_secs   = 0;
      running    = 1'b0;
      mismatches = 0;
      shows      = 0;
      clears     = 0;
      errors     = 0;
      codes_seen = '0;
    endfunction

    function void clear_msg();
      foreach (msg_buf[i]) msg_buf[i] = CH_NUL;
      msg_len  = '0;
      nul_seen = 1'b0;
    endfunction

    function int pending();
      return due.size();
    endfunction

    // show the current time, then advance one second
    function void expect_show();
      clock_result_t r;
      r = '0;
      r.kind    = KIND_SHOW;
      r.hours   = 5'((day_secs / HOUR_SECS) % 24);
      r.minutes = 6'((day_secs / 60) % 60);
      r.secs    = 6'(day_secs % 60);
      due.push_back(r);
      day_secs = (day_secs + 1) % DAY_SECS;
    endfunction

    function void expect_flag(logic [1:0] kind, logic [3:0] code, logic [3:0] n);
      clock_result_t r;
      r = '0;
      r.kind       = kind;
      r.code       = code;
      r.msg_length = n;
      due.push_back(r);
    endfunction

    function void start_counting();
      if (!running) begin
        running = 1'b1;
        expect_show();
      end
    endfunction

    function bit numeral(char_t c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function int unsigned two_digit(int p);
      return (int'(msg_buf[p]) - int'(CH_ZERO)) * 10 + (int'(msg_buf[p+1]) - int'(CH_ZERO));
    endfunction

    function void decode_message();
      logic [3:0] n;
      n = msg_len;
      if (n < 2 || msg_buf[0] != CH_PERCENT || msg_buf[1] != CH_W) return;
      case (msg_buf[2])
        CH_R: begin
          if (n != LEN_SHORT_CMD) expect_flag(KIND_ERROR, ERR_R_LEN, n);
          else begin
            day_secs = 0;
            start_counting();
          end
        end
        CH_S: begin
          if (n != LEN_SET_CMD) expect_flag(KIND_ERROR, ERR_S_LEN, n);
          else if (msg_buf[3] != CH_SPACE) expect_flag(KIND_ERROR, ERR_SPACE, n);
          else if (msg_buf[6] != CH_COLON || msg_buf[9] != CH_COLON)
            expect_flag(KIND_ERROR, ERR_COLON, n);
          else if (!numeral(msg_buf[4]) || !numeral(msg_buf[5]))
            expect_flag(KIND_ERROR, ERR_HOUR, n);
          else if (!numeral(msg_buf[7]) || !numeral(msg_buf[8]))
            expect_flag(KIND_ERROR, ERR_MINUTE, n);
          else if (!numeral(msg_buf[10]) || !numeral(msg_buf[11]))
            expect_flag(KIND_ERROR, ERR_SECOND, n);
          else begin
            // no range check: raw value is kept, display reduces it
            day_secs = two_digit(4) * HOUR_SECS + two_digit(7) * 60 + two_digit(10);
            start_counting();
          end
        end
        CH_T: begin
          if (n != LEN_SHORT_CMD) expect_flag(KIND_ERROR, ERR_T_LEN, n);
          else begin
            running = 1'b0;
            expect_flag(KIND_CLEAR, '0, '0);
          end
        end
        default: expect_flag(KIND_ERROR, ERR_UNKNOWN, n);
      endcase
    endfunction

    function void note_input(logic cmd, char_t ch, logic eom);
      if (cmd == CMD_TICK) begin
        if (running) expect_show();
        return;
      end
      if (!nul_seen) begin
        if (ch == CH_NUL) nul_seen = 1'b1;
        else begin
          if (msg_len < MSG_DEPTH) msg_buf[msg_len] = ch;
          if (msg_len < LEN_MAX) msg_len++;
        end
      end
      if (eom) begin
        decode_message();
        clear_msg();
      end
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 30) $display("[board] %0t: %s", $time, what);
    endtask

    task compare(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    task check_result(clock_result_t got);
      clock_result_t want;
      if (due.size() == 0) begin
        report($sformatf("result kind %0d with nothing expected", got.kind));
        return;
      end
      want = due.pop_front();
      compare("kind", 8'(got.kind), 8'(want.kind));
      compare("hours", 8'(got.hours), 8'(want.hours));
      compare("minutes", 8'(got.minutes), 8'(want.minutes));
      compare("secs", 8'(got.secs), 8'(want.secs));
      compare("error_code", 8'(got.code), 8'(want.code));
      compare("message_length", 8'(got.msg_length), 8'(want.msg_length));
      case (want.kind)
        KIND_SHOW:  shows++;
        KIND_CLEAR: clears++;
        default: begin
          errors++;
          codes_seen[want.code] = 1'b1;
        end
      endcase
    endtask
  endclass

endpackage

### tb/tb_top.sv
// Top level testbench for command_driven_wall_clock: stimulus, idling and end of run.
// Depends on cdwc_pkg and wall_clock_board_pkg (tb/wall_clock_board_pkg.sv).
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cdwc_pkg::*;
  import wall_clock_board_pkg::*;

  localparam int RAND_BEATS   = 1950;
  localparam int CALM_FROM    = 600;    // stretch without any idling on either side
  localparam int CALM_TO      = 1000;
  localparam int HOLD_AT      = 1300;   // sender waits for every result here
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_command = CMD_TICK;
  logic [7:0] in_char_code = '0;
  logic       in_end_of_message = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_result_kind;
  logic [4:0] out_hours;
  logic [5:0] out_minutes;
  logic [5:0] out_secs;
  logic [3:0] out_error_code;
  logic [3:0] out_message_length;

  wall_clock_board board = new();
  char_t           msg_q[$];
  int              beats = 0;
  int              cycles = 0;
  bit              calm = 1'b0;

  command_driven_wall_clock dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_char_code       (in_char_code),
    .in_end_of_message  (in_end_of_message),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_hours          (out_hours),
    .out_minutes        (out_minutes),
    .out_secs           (out_secs),
    .out_error_code     (out_error_code),
    .out_message_length (out_message_length)
  );

  always #5 clk = ~clk;

  // Watchdog: give up well past the slowest legal run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Receiver stalls at random, except during the calm stretch.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 30);
  end

  // Both monitors sample at the edge, before any nonblocking update lands.
  // Check the result first: a beat accepted now can only produce a result later.
  always @(posedge clk) begin
    clock_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.kind       = out_result_kind;
      got.hours      = out_hours;
      got.minutes    = out_minutes;
      got.secs       = out_secs;
      got.code       = out_error_code;
      got.msg_length = out_message_length;
      board.check_result(got);
    end
    if (rst_n && in_valid && !in_stall)
      board.note_input(in_command, in_char_code, in_end_of_message);
  end

  // Now and then drop valid for a random idle spell; scramble the idle payload.
  task idle_gap();
    if (!calm && $urandom_range(99) < 30) begin
      in_valid          <= 1'b0;
      in_command        <= 1'($urandom);
      in_char_code      <= 8'($urandom);
      in_end_of_message <= 1'($urandom);
      @(posedge clk);
      while ($urandom_range(99) < 30) @(posedge clk);
    end
  endtask

  // Present one beat and hold it until the block takes it.
  task put_beat(logic cmd, char_t ch, logic eom);
    idle_gap();
    in_valid          <= 1'b1;
    in_command        <= cmd;
    in_char_code      <= ch;
    in_end_of_message <= eom;
    do @(posedge clk); while (!(in_valid && !in_stall));
    beats++;
  endtask

  // Character and end flag are don't-care on a tick; randomize them anyway.
  task tick();
    put_beat(CMD_TICK, 8'($urandom), 1'($urandom));
  endtask

  // Send the queued message, sprinkling ticks between characters.
  task send_msg(int tick_pct);
    for (int i = 0; i < msg_q.size(); i++) begin
      if ($urandom_range(99) < tick_pct) tick();
      put_beat(CMD_CHAR, msg_q[i], i == msg_q.size() - 1);
    end
  endtask

  task add_text(string s);
    for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
  endtask

  task add_pair(int v);
    msg_q.push_back(8'(CH_ZERO + v / 10));
    msg_q.push_back(8'(CH_ZERO + v % 10));
  endtask

  task add_junk(int n);
    repeat (n) msg_q.push_back(8'($urandom_range(1, 255)));
  endtask

  // Break a well-formed command: swap a byte, cut the text short with a
  // zero byte, drop a byte, or make it longer.
  task mangle();
    int pos;
    pos = $urandom_range(2, msg_q.size() - 1);
    case ($urandom_range(3))
      0: msg_q[pos] = $urandom_range(1) ? 8'($urandom_range(1, 255))
                                        : 8'($urandom_range(8'h2F, 8'h3A));
      1: msg_q[pos] = CH_NUL;
      2: msg_q.delete(pos);
      default: add_junk($urandom_range(1, 6));
    endcase
  endtask

  task build_set();
    int hh;
    int mm;
    int ss;
    msg_q.delete();
    if ($urandom_range(4) == 0) begin
      // just before midnight, so the following ticks wrap the day
      hh = 23;
      mm = 59;
      ss = $urandom_range(50, 59);
    end else begin
      hh = $urandom_range(99);
      mm = $urandom_range(99);
      ss = $urandom_range(99);
    end
    add_text("%WS ");
    add_pair(hh);
    msg_q.push_back(CH_COLON);
    add_pair(mm);
    msg_q.push_back(CH_COLON);
    add_pair(ss);
    add_junk(2);
    if ($urandom_range(99) < 35) mangle();
  endtask

  task build_short(char_t letter);
    msg_q.delete();
    add_text("%W");
    msg_q.push_back(letter);
    add_junk(2);
    if ($urandom_range(99) < 30) mangle();
  endtask

  // Command prefix with any third character, or with none at all.
  task build_unknown();
    msg_q.delete();
    add_text("%W");
    if ($urandom_range(4) != 0) begin
      msg_q.push_back($urandom_range(9) == 0 ? CH_NUL : 8'($urandom_range(1, 255)));
      add_junk($urandom_range(13));
    end
  endtask

  // Arbitrary bytes, zero included; long ones saturate the length.
  task build_noise();
    int n;
    msg_q.delete();
    n = $urandom_range(1, 20);
    for (int i = 0; i < n; i++) msg_q.push_back(8'($urandom));
    if ($urandom_range(99) < 30) msg_q[0] = CH_PERCENT;
    if (n > 1 && $urandom_range(1) == 1) msg_q[1] = CH_W;
  endtask

  initial begin
    int  first_rand;
    int  pick;
    bit  held;

    held = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: tick while stopped, largest raw set from stopped, tick,
    // stop, reset from stopped, tick.
    tick();
    msg_q.delete();
    add_text("%WS 99:99:99\r\n");
    send_msg(0);
    tick();
    msg_q.delete();
    add_text("%WT\r\n");
    send_msg(0);
    msg_q.delete();
    add_text("%WR\r\n");
    send_msg(0);
    tick();

    // Random: mostly commands with random content, the rest noise and ticks.
    first_rand = beats;
    while (beats - first_rand < RAND_BEATS) begin
      calm = (beats - first_rand >= CALM_FROM) && (beats - first_rand < CALM_TO);
      if (!held && beats - first_rand >= HOLD_AT) begin
        // hold the sender until everything in flight has come out
        held = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
      end
      pick = $urandom_range(99);
      if (pick < 28) begin
        build_set();
        send_msg(10);
      end else if (pick < 40) begin
        build_short(CH_R);
        send_msg(10);
      end else if (pick < 50) begin
        build_short(CH_T);
        send_msg(10);
      end else if (pick < 58) begin
        build_unknown();
        send_msg(10);
      end else if (pick < 70) begin
        build_noise();
        send_msg(10);
      end else begin
        repeat ($urandom_range(1, 8)) tick();
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain, then linger so a stray result still gets caught. Step the clock
    // first so the last accepted beat is already on the board.
    do @(posedge clk); while (board.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d beats; checked %0d time shows, %0d display clears, %0d error reports.",
             beats, board.shows, board.clears, board.errors);
    $display("Error codes reported (one bit per code, code 0 rightmost): %b", board.codes_seen);
    if (board.mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
